/* rtl/cfifo_pkg.sv */
// ----------------------------------------------------------------------------
// Circular FIFO with search: shared package
// Depth, widths, operation and status codes, controller states and the
// command and status bundles that pass between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package cfifo_pkg;

  localparam int unsigned DEPTH   = 16;
  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OPC_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned COUNT_W = 5;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [OPC_W-1:0] {
    OP_ENQ      = 3'd0,
    OP_DEQ      = 3'd1,
    OP_PEEK     = 3'd2,
    OP_CONTAINS = 3'd3,
    OP_CLEAR    = 3'd4,
    OP_COUNT    = 3'd5
  } op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PEEK,
    S_SCAN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic load_now;
    logic scan_start;
    logic scan_step;
    logic fin_peek;
    logic fin_hit;
    logic fin_miss;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic match;
    logic last;
    logic out_busy;
  } sts_t;

  function automatic ptr_t ring_next(ptr_t p);
    ptr_t r;
    if (p == PTR_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/cfifo_in_if.sv */
// ----------------------------------------------------------------------------
// Circular FIFO with search: request channel
// Valid/ready channel carrying the operation code and the operand word.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfifo_in_if;
  logic                                valid;
  logic                                ready;
  logic [cfifo_pkg::OPC_W-1:0]         opcode;
  logic signed [cfifo_pkg::DATA_W-1:0] value;

  modport source (output valid, opcode, value, input ready);
  modport sink   (input valid, opcode, value, output ready);
endinterface

`default_nettype wire

/* rtl/cfifo_out_if.sv */
// ----------------------------------------------------------------------------
// Circular FIFO with search: response channel
// Valid/ready channel carrying status, head word, search flag and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface cfifo_out_if;
  logic                                valid;
  logic                                ready;
  logic [cfifo_pkg::STAT_W-1:0]        status;
  logic signed [cfifo_pkg::DATA_W-1:0] head_data;
  logic                                found;
  logic [cfifo_pkg::COUNT_W-1:0]       count;

  modport source (output valid, status, head_data, found, count, input ready);
  modport sink   (input valid, status, head_data, found, count, output ready);
endinterface

`default_nettype wire

/* rtl/cfifo_ctrl.sv */
// ----------------------------------------------------------------------------
// Circular FIFO with search: controller
// Sequences the operations that complete on acceptance, the head read of a peek and the
// entry-by-entry comparison of a contains search.
// ----------------------------------------------------------------------------
`default_nettype none

module cfifo_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  input  wire logic [cfifo_pkg::OPC_W-1:0] in_opcode_i,
  input  wire cfifo_pkg::sts_t             sts_i,
  output logic                             in_ready_o,
  output cfifo_pkg::cmd_t                  cmd_o
);

  cfifo_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfifo_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      cfifo_pkg::S_IDLE: begin
        in_ready_o   = !sts_i.out_busy;
        cmd_o.accept = in_valid_i && !sts_i.out_busy;
        if (cmd_o.accept) begin
          if (in_opcode_i == cfifo_pkg::OP_PEEK && !sts_i.empty) begin
            state_d = cfifo_pkg::S_PEEK;
          end else if (in_opcode_i == cfifo_pkg::OP_CONTAINS && !sts_i.empty) begin
            state_d          = cfifo_pkg::S_SCAN;
            cmd_o.scan_start = 1'b1;
          end else begin
            cmd_o.load_now = 1'b1;
          end
        end
      end
      cfifo_pkg::S_PEEK: begin
        cmd_o.fin_peek = 1'b1;
        state_d        = cfifo_pkg::S_IDLE;
      end
      cfifo_pkg::S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.match) begin
          cmd_o.fin_hit = 1'b1;
          state_d       = cfifo_pkg::S_IDLE;
        end else if (sts_i.last) begin
          cmd_o.fin_miss = 1'b1;
          state_d        = cfifo_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cfifo_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/cfifo_dp.sv */
// ----------------------------------------------------------------------------
// Circular FIFO with search: datapath
// Ring storage, head and tail pointers, occupancy, search pointer and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfifo_dp (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire cfifo_pkg::cmd_t                    cmd_i,
  input  wire logic [cfifo_pkg::OPC_W-1:0]        in_opcode_i,
  input  wire logic signed [cfifo_pkg::DATA_W-1:0] in_value_i,
  input  wire logic                               out_ready_i,
  output cfifo_pkg::sts_t                         sts_o,
  output logic                                    out_valid_o,
  output logic [cfifo_pkg::STAT_W-1:0]            out_status_o,
  output logic signed [cfifo_pkg::DATA_W-1:0]     out_head_data_o,
  output logic                                    out_found_o,
  output logic [cfifo_pkg::COUNT_W-1:0]           out_count_o
);

  localparam cfifo_pkg::cnt_t DepthC = cfifo_pkg::CNT_W'(cfifo_pkg::DEPTH);

  logic [cfifo_pkg::DATA_W-1:0] mem_q [cfifo_pkg::DEPTH];
  logic [cfifo_pkg::DATA_W-1:0] rdata_q;
  logic [cfifo_pkg::DATA_W-1:0] value_q;

  cfifo_pkg::ptr_t head_q, head_d, tail_q, tail_d, scan_q, scan_d, rd_addr;
  cfifo_pkg::cnt_t occ_q, occ_d, rem_q, rem_d;

  logic                          out_valid_q, out_valid_d;
  logic [cfifo_pkg::STAT_W-1:0]  status_q, status_d;
  logic [cfifo_pkg::DATA_W-1:0]  hdata_q, hdata_d;
  logic                          found_q, found_d;
  logic [cfifo_pkg::COUNT_W-1:0] count_q, count_d;
  logic [cfifo_pkg::CNT_W+cfifo_pkg::COUNT_W-1:0] occ_ext;

  logic empty, full, do_write, load;

  assign empty    = (occ_q == '0);
  assign full     = (occ_q == DepthC);
  assign do_write = cmd_i.load_now && in_opcode_i == cfifo_pkg::OP_ENQ && !full;
  assign rd_addr  = cmd_i.scan_step ? scan_q : head_q;
  assign load     = cmd_i.load_now || cmd_i.fin_peek || cmd_i.fin_hit || cmd_i.fin_miss;

  assign sts_o.empty    = empty;
  assign sts_o.match    = (rdata_q == value_q);
  assign sts_o.last     = (rem_q == cfifo_pkg::CNT_W'(1));
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  // Storage: one write port at the tail, one registered read port.
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[tail_q] <= in_value_i;
    end
    rdata_q <= mem_q[rd_addr];
    if (cmd_i.accept) begin
      value_q <= in_value_i;
    end
  end

  // Pointer, occupancy and search updates.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    occ_d  = occ_q;
    scan_d = scan_q;
    rem_d  = rem_q;
    if (cmd_i.load_now) begin
      unique case (in_opcode_i)
        cfifo_pkg::OP_ENQ: begin
          if (!full) begin
            tail_d = cfifo_pkg::ring_next(tail_q);
            occ_d  = occ_q + cfifo_pkg::CNT_W'(1);
          end
        end
        cfifo_pkg::OP_DEQ: begin
          if (!empty) begin
            head_d = cfifo_pkg::ring_next(head_q);
            occ_d  = occ_q - cfifo_pkg::CNT_W'(1);
          end
        end
        cfifo_pkg::OP_CLEAR: begin
          head_d = '0;
          tail_d = '0;
          occ_d  = '0;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.scan_start) begin
      scan_d = cfifo_pkg::ring_next(head_q);
      rem_d  = occ_q;
    end else if (cmd_i.scan_step) begin
      scan_d = cfifo_pkg::ring_next(scan_q);
      rem_d  = rem_q - cfifo_pkg::CNT_W'(1);
    end
  end

  assign occ_ext = {{cfifo_pkg::COUNT_W{1'b0}}, occ_d};

  // Response register.
  always_comb begin
    status_d    = status_q;
    hdata_d     = hdata_q;
    found_d     = found_q;
    count_d     = count_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      out_valid_d = 1'b1;
      status_d    = cfifo_pkg::ST_OK;
      hdata_d     = '0;
      found_d     = 1'b0;
      count_d     = occ_ext[cfifo_pkg::COUNT_W-1:0];
      if (cmd_i.load_now) begin
        if (in_opcode_i == cfifo_pkg::OP_ENQ && full) begin
          status_d = cfifo_pkg::ST_FULL;
        end else if (empty && (in_opcode_i == cfifo_pkg::OP_DEQ ||
                               in_opcode_i == cfifo_pkg::OP_PEEK ||
                               in_opcode_i == cfifo_pkg::OP_CONTAINS)) begin
          status_d = cfifo_pkg::ST_EMPTY;
        end
      end
      if (cmd_i.fin_peek) begin
        hdata_d = rdata_q;
      end
      if (cmd_i.fin_hit) begin
        found_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      scan_q      <= '0;
      rem_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      scan_q      <= scan_d;
      rem_q       <= rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    hdata_q  <= hdata_d;
    found_q  <= found_d;
    count_q  <= count_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_status_o    = status_q;
  assign out_head_data_o = hdata_q;
  assign out_found_o     = found_q;
  assign out_count_o     = count_q;

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= DepthC)
    else $error("occupancy exceeds the depth");

  a_scan_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_step |-> rem_q != '0)
    else $error("search step with no entries left to compare");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !load)
    else $error("response register overwritten before it was taken");

  a_empty_pointers : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q == '0) |-> head_q == tail_q)
    else $error("empty queue with head and tail apart");

endmodule

`default_nettype wire

/* rtl/circular_fifo_with_search_core.sv */
// ----------------------------------------------------------------------------
// Circular FIFO with search: top level
// Fixed-depth ring buffer of signed words with enqueue, dequeue, peek,
// contains search, clear and count operations, one response per request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake      Payload
//   in_i      sink       valid/ready    opcode[2:0], value[31:0]
//   out_o     source     valid/ready    status[1:0], head_data[31:0],
//                                       found, count[4:0]
//
// Enqueue, dequeue, clear, count, unknown codes and any operation on an
// empty queue complete in the cycle the transaction is accepted.
// A peek passes through the peek state, as the storage read port is registered.
// A contains search compares one entry per cycle in the scan state through
// the single read port, up to the first match or at most the occupancy;
// with a depth of 16 this is at most 16 entries.
// Reset clears the pointers, the occupancy and the response valid; the
// storage is not cleared, as only entries that have been written are read.
// A request is accepted in the idle state while the response register is
// empty or being taken; a stalled response holds off only the next request.
`default_nettype none

module circular_fifo_with_search_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cfifo_in_if.sink  in_i,
  cfifo_out_if.source out_o
);

  // Commands and status between the controller and the datapath.
  cfifo_pkg::cmd_t cmd;
  cfifo_pkg::sts_t sts;

  // The controller owns the request handshake and the operation sequence.
  cfifo_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_opcode_i (in_i.opcode),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .cmd_o       (cmd)
  );

  // The datapath holds the ring, the pointers and the response register.
  cfifo_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .in_opcode_i     (in_i.opcode),
    .in_value_i      (in_i.value),
    .out_ready_i     (out_o.ready),
    .sts_o           (sts),
    .out_valid_o     (out_o.valid),
    .out_status_o    (out_o.status),
    .out_head_data_o (out_o.head_data),
    .out_found_o     (out_o.found),
    .out_count_o     (out_o.count)
  );

endmodule

`default_nettype wire

/* bench/tb_circular_fifo_with_search_core.sv */
// ----------------------------------------------------------------------------
// Circular FIFO with search: self-checking testbench
// Drives opcode/value requests through the request channel and checks every
// response against a behavioural mirror of the ring buffer. A directed part
// covers the empty, full, wrap, clear and unknown-code cases. Random traffic
// with idling on both channels follows, then a final stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_circular_fifo_with_search_core;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes that the block does not decode; they must behave as a no-op.
  localparam logic [cfifo_pkg::OPC_W-1:0] OPC_SPARE_6 = 3'd6;
  localparam logic [cfifo_pkg::OPC_W-1:0] OPC_SPARE_7 = 3'd7;

  localparam logic signed [cfifo_pkg::DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [cfifo_pkg::DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

  // A contains search compares at most DEPTH entries, so a short drain and a
  // generous watchdog are plenty.
  localparam int unsigned DRAIN_CYCLES   = 2 * cfifo_pkg::DEPTH + 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    cfifo_pkg::status_e                  status;
    logic signed [cfifo_pkg::DATA_W-1:0] head_data;
    logic                                found;
    logic [cfifo_pkg::COUNT_W-1:0]       count;
  } fifo_resp_t;

  logic clk_i;
  logic rst_ni;

  cfifo_in_if  in_if ();
  cfifo_out_if out_if ();

  circular_fifo_with_search_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Mirror of the ring buffer, updated when a request transaction is accepted.
  logic signed [cfifo_pkg::DATA_W-1:0] mirror_words [cfifo_pkg::DEPTH];
  int unsigned                         mirror_head;
  int unsigned                         mirror_tail;
  int unsigned                         mirror_fill;

  // Responses that the block still owes, oldest first.
  fifo_resp_t  pending_responses [$];
  fifo_resp_t  oldest_expected;
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          idling_on;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Works out the response to one request and advances the mirror, exactly as
  // the block should when it accepts the transaction.
  function automatic fifo_resp_t predict_response(
      logic [cfifo_pkg::OPC_W-1:0] opc,
      logic signed [cfifo_pkg::DATA_W-1:0] val);
    fifo_resp_t  r;
    int unsigned p;
    r.status    = cfifo_pkg::ST_OK;
    r.head_data = '0;
    r.found     = 1'b0;
    case (opc)
      cfifo_pkg::OP_ENQ: begin
        if (mirror_fill >= cfifo_pkg::DEPTH) begin
          r.status = cfifo_pkg::ST_FULL;
        end else begin
          mirror_words[mirror_tail] = val;
          mirror_tail = (mirror_tail + 1) % cfifo_pkg::DEPTH;
          mirror_fill++;
        end
      end
      cfifo_pkg::OP_DEQ: begin
        if (mirror_fill == 0) begin
          r.status = cfifo_pkg::ST_EMPTY;
        end else begin
          mirror_head = (mirror_head + 1) % cfifo_pkg::DEPTH;
          mirror_fill--;
        end
      end
      cfifo_pkg::OP_PEEK: begin
        if (mirror_fill == 0) begin
          r.status = cfifo_pkg::ST_EMPTY;
        end else begin
          r.head_data = mirror_words[mirror_head];
        end
      end
      cfifo_pkg::OP_CONTAINS: begin
        if (mirror_fill == 0) begin
          r.status = cfifo_pkg::ST_EMPTY;
        end else begin
          // Scan from the head over the occupied entries only.
          p = mirror_head;
          for (int unsigned i = 0; i < mirror_fill; i++) begin
            if (mirror_words[p] == val) begin
              r.found = 1'b1;
              break;
            end
            p = (p + 1) % cfifo_pkg::DEPTH;
          end
        end
      end
      cfifo_pkg::OP_CLEAR: begin
        mirror_head = 0;
        mirror_tail = 0;
        mirror_fill = 0;
      end
      default: begin
      end
    endcase
    r.count = cfifo_pkg::COUNT_W'(mirror_fill);
    return r;
  endfunction

  // Sends one request. Inputs change on the falling edge; the transaction is
  // taken at the first rising edge that sees ready high, and the expected
  // response is recorded at that very edge.
  task automatic send_request(input logic [cfifo_pkg::OPC_W-1:0] opc,
                              input logic signed [cfifo_pkg::DATA_W-1:0] val);
    int unsigned gap;
    @(negedge clk_i);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.opcode = opc;
    in_if.value  = val;
    do @(posedge clk_i); while (!in_if.ready);
    pending_responses.push_back(predict_response(opc, val));
  endtask

  // A word from a mix of fully random values, a small range that makes
  // duplicates likely, and the extremes of the signed range.
  function automatic logic signed [cfifo_pkg::DATA_W-1:0] pick_word();
    logic signed [cfifo_pkg::DATA_W-1:0] w;
    case ($urandom_range(0, 3))
      0: w = $signed(cfifo_pkg::DATA_W'($urandom_range(0, 7))) - 32'sd4;
      1: begin
        case ($urandom_range(0, 3))
          0:       w = WORD_MIN;
          1:       w = WORD_MAX;
          2:       w = '0;
          default: w = -32'sd1;
        endcase
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  // Every operation that needs an occupied queue, tried on an empty one, plus
  // the read count and the two unknown codes.
  task automatic test_empty_queue();
    send_request(cfifo_pkg::OP_COUNT, 32'sd0);
    send_request(cfifo_pkg::OP_DEQ, 32'sd5);
    send_request(cfifo_pkg::OP_PEEK, WORD_MAX);
    send_request(cfifo_pkg::OP_CONTAINS, 32'sd0);
    send_request(OPC_SPARE_6, WORD_MIN);
    send_request(OPC_SPARE_7, -32'sd1);
  endtask

  // The extremes of the word range are stored, peeked and searched for; the
  // search for zero must miss as zero was never stored.
  task automatic test_extreme_words();
    send_request(cfifo_pkg::OP_ENQ, WORD_MIN);
    send_request(cfifo_pkg::OP_ENQ, WORD_MAX);
    send_request(cfifo_pkg::OP_PEEK, 32'sd0);
    send_request(cfifo_pkg::OP_CONTAINS, WORD_MAX);
    send_request(cfifo_pkg::OP_CONTAINS, 32'sd0);
  endtask

  // Fills the queue, has one enqueue rejected, finds the word at the tail,
  // wraps the tail pointer and finally clears a non-empty and an empty queue.
  task automatic test_full_and_clear();
    logic signed [cfifo_pkg::DATA_W-1:0] last_word;
    last_word = '0;
    while (mirror_fill < cfifo_pkg::DEPTH) begin
      last_word = $urandom;
      send_request(cfifo_pkg::OP_ENQ, last_word);
    end
    send_request(cfifo_pkg::OP_ENQ, 32'sd7);
    send_request(cfifo_pkg::OP_CONTAINS, last_word);
    send_request(cfifo_pkg::OP_DEQ, 32'sd0);
    send_request(cfifo_pkg::OP_ENQ, -32'sd2);
    send_request(cfifo_pkg::OP_CLEAR, 32'sd0);
    send_request(cfifo_pkg::OP_CLEAR, WORD_MAX);
  endtask

  // Random traffic in phases that lean towards filling, draining or neither,
  // so that the occupancy travels over its whole range and the pointers wrap
  // many times. Half of the searches look for a word that is in the queue.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned                         enq_weight;
    int unsigned                         roll;
    logic [cfifo_pkg::OPC_W-1:0]         opc;
    logic signed [cfifo_pkg::DATA_W-1:0] val;
    enq_weight = 30;
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_weight = 48;
          1:       enq_weight = 12;
          default: enq_weight = 30;
        endcase
      end
      roll = $urandom_range(0, 99);
      if (roll < enq_weight) begin
        opc = cfifo_pkg::OP_ENQ;
      end else if (roll < 60) begin
        opc = cfifo_pkg::OP_DEQ;
      end else if (roll < 70) begin
        opc = cfifo_pkg::OP_PEEK;
      end else if (roll < 90) begin
        opc = cfifo_pkg::OP_CONTAINS;
      end else if (roll < 92) begin
        opc = cfifo_pkg::OP_CLEAR;
      end else if (roll < 96) begin
        opc = cfifo_pkg::OP_COUNT;
      end else if (roll < 98) begin
        opc = OPC_SPARE_6;
      end else begin
        opc = OPC_SPARE_7;
      end
      val = pick_word();
      if (opc == cfifo_pkg::OP_CONTAINS && mirror_fill > 0 &&
          $urandom_range(0, 1) == 1) begin
        val = mirror_words[(mirror_head + $urandom_range(0, mirror_fill - 1)) %
                           cfifo_pkg::DEPTH];
      end
      send_request(opc, val);
    end
  endtask

  // Response side: ready is dropped in random bursts while idling is enabled.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      out_if.ready = 1'b0;
      stall_left = $urandom_range(0, 3);
    end else begin
      out_if.ready = 1'b1;
    end
  end

  // Every response transaction is compared field by field with the oldest
  // expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_responses.size() == 0) begin
        $display("%0t: response with none expected: status %0d data %0d found %0d count %0d",
                 $time, out_if.status, out_if.head_data, out_if.found, out_if.count);
        error_count++;
      end else begin
        oldest_expected = pending_responses.pop_front();
        if (out_if.status !== oldest_expected.status) begin
          $display("%0t: status expected %0d, got %0d",
                   $time, oldest_expected.status, out_if.status);
          error_count++;
        end
        if (out_if.head_data !== oldest_expected.head_data) begin
          $display("%0t: head_data expected %0d, got %0d",
                   $time, oldest_expected.head_data, out_if.head_data);
          error_count++;
        end
        if (out_if.found !== oldest_expected.found) begin
          $display("%0t: found expected %0d, got %0d",
                   $time, oldest_expected.found, out_if.found);
          error_count++;
        end
        if (out_if.count !== oldest_expected.count) begin
          $display("%0t: count expected %0d, got %0d",
                   $time, oldest_expected.count, out_if.count);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too many cycles without any transaction means the block hangs.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.opcode = cfifo_pkg::OP_COUNT;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    idling_on    = 1'b0;
    stall_left   = 0;
    error_count  = 0;
    quiet_cycles = 0;
    mirror_head  = 0;
    mirror_tail  = 0;
    mirror_fill  = 0;
    for (int unsigned i = 0; i < cfifo_pkg::DEPTH; i++) begin
      mirror_words[i] = '0;
    end
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed cases run with idling so that stalls fall on peeks and scans.
    idling_on = 1'b1;
    test_empty_queue();
    test_extreme_words();
    test_full_and_clear();
    test_random_traffic(1000);

    // The last stretch runs back to back at full rate.
    idling_on = 1'b0;
    test_random_traffic(250);

    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* circular_fifo_with_search_core.f */
rtl/cfifo_pkg.sv
rtl/cfifo_in_if.sv
rtl/cfifo_out_if.sv
rtl/cfifo_ctrl.sv
rtl/cfifo_dp.sv
rtl/circular_fifo_with_search_core.sv
bench/tb_circular_fifo_with_search_core.sv
